// ----- design/srt_pkg.sv -----
package srt_pkg;

  localparam int SLOT_W  = 6;
  localparam int ROBOT_W = 8;
  localparam int FUNC_W  = 3;
  localparam int RTYPE_W = 2;

  localparam int LAST_SLOT_DEF     = 63;
  localparam int ROBOT_ID_BITS_DEF = 8;

  localparam logic [FUNC_W-1:0] FUNC_RESERVE = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_EXPIRE  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_WINDOWS = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_HELD    = 3'd4;

  localparam logic [RTYPE_W-1:0] RTYPE_RESET       = 2'd3;
  localparam logic [RTYPE_W-1:0] RTYPE_ALWAYS_FREE = 2'd1;

endpackage

// ----- design/srt_cell.sv -----
module srt_cell #(
  parameter int OWNER_BITS = srt_pkg::ROBOT_ID_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  shift_i,
  input  logic                  taken_i,
  input  logic [OWNER_BITS-1:0] owner_i,
  output logic                  taken_o,
  output logic [OWNER_BITS-1:0] owner_o
);

  logic                  taken_q;
  logic [OWNER_BITS-1:0] owner_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q <= 1'b0;
      owner_q <= '0;
    end else if (shift_i) begin
      taken_q <= taken_i;
      owner_q <= owner_i;
    end
  end

  assign taken_o = taken_q;
  assign owner_o = owner_q;

endmodule

// ----- design/srt_ctrl.sv -----
module srt_ctrl #(
  parameter int LAST_SLOT     = srt_pkg::LAST_SLOT_DEF,
  parameter int ROBOT_ID_BITS = srt_pkg::ROBOT_ID_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [srt_pkg::FUNC_W-1:0]  func_i,
  input  logic [srt_pkg::ROBOT_W-1:0] robot_i,
  input  logic [srt_pkg::SLOT_W-1:0]  first_slot_i,
  input  logic [srt_pkg::SLOT_W-1:0]  last_slot_i,
  input  logic [srt_pkg::SLOT_W-1:0]  current_slot_i,
  input  logic [srt_pkg::RTYPE_W-1:0] rtype_i,
  input  logic                        head_taken_i,
  input  logic [ROBOT_ID_BITS-1:0]    head_owner_i,
  output logic                        shift_o,
  output logic                        tail_taken_o,
  output logic [ROBOT_ID_BITS-1:0]    tail_owner_o,
  output logic                        result_valid_o,
  output logic                        ok_o,
  output logic                        found_o,
  output logic [srt_pkg::SLOT_W-1:0]  range_start_o,
  output logic [srt_pkg::SLOT_W-1:0]  range_end_o,
  output logic                        last_o
);
  import srt_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_CLAIM = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  localparam logic [SLOT_W-1:0] LastIdx = SLOT_W'(LAST_SLOT);

  logic [1:0]               st_q, st_d;
  logic [SLOT_W-1:0]        idx_q, idx_d;
  logic [FUNC_W-1:0]        func_q, func_d;
  logic [ROBOT_ID_BITS-1:0] id_q, id_d;
  logic [SLOT_W-1:0]        first_q, first_d, lastsl_q, lastsl_d, cur_q, cur_d;
  logic                     conflict_q, conflict_d;
  logic                     inrun_q, inrun_d;
  logic [SLOT_W-1:0]        start_q, start_d;
  logic                     pend_v_q, pend_v_d;
  logic [SLOT_W-1:0]        pend_rs_q, pend_rs_d, pend_re_q, pend_re_d;
  logic                     strobe_q, strobe_d, ok_q, ok_d, found_q, found_d, last_q, last_d;
  logic [SLOT_W-1:0]        rs_q, rs_d, re_q, re_d;

  always_comb begin
    logic              is_end;
    logic              own;
    logic              in_range;
    logic              range_ok;
    logic              blocked;
    logic              new_v;
    logic [SLOT_W-1:0] new_rs;
    logic [SLOT_W-1:0] new_re;

    is_end   = (idx_q == LastIdx);
    own      = head_taken_i && (head_owner_i == id_q);
    in_range = (idx_q >= first_q) && (idx_q <= lastsl_q);
    range_ok = (first_q != '0) && (first_q <= lastsl_q) && (lastsl_q <= LastIdx);
    blocked  = head_taken_i && (head_owner_i != id_q);
    new_v    = 1'b0;
    new_rs   = '0;
    new_re   = '0;

    st_d       = st_q;
    idx_d      = idx_q;
    func_d     = func_q;
    id_d       = id_q;
    first_d    = first_q;
    lastsl_d   = lastsl_q;
    cur_d      = cur_q;
    conflict_d = conflict_q;
    inrun_d    = inrun_q;
    start_d    = start_q;
    pend_v_d   = pend_v_q;
    pend_rs_d  = pend_rs_q;
    pend_re_d  = pend_re_q;

    strobe_d = 1'b0;
    ok_d     = 1'b1;
    found_d  = 1'b0;
    rs_d     = '0;
    re_d     = '0;
    last_d   = 1'b0;

    tail_taken_o = head_taken_i;
    tail_owner_o = head_owner_i;

    unique case (st_q)
      ST_IDLE: begin
        if (start_i) begin
          func_d     = func_i;
          id_d       = ROBOT_ID_BITS'(robot_i);
          first_d    = first_slot_i;
          lastsl_d   = last_slot_i;
          cur_d      = current_slot_i;
          idx_d      = '0;
          conflict_d = 1'b0;
          inrun_d    = 1'b0;
          pend_v_d   = 1'b0;
          unique case (func_i)
            FUNC_RESERVE, FUNC_RELEASE, FUNC_EXPIRE, FUNC_HELD: st_d = ST_SCAN;
            FUNC_WINDOWS: begin
              if (rtype_i == RTYPE_ALWAYS_FREE) begin
                strobe_d = 1'b1;
                found_d  = 1'b1;
                rs_d     = SLOT_W'(1);
                re_d     = LastIdx;
                last_d   = 1'b1;
              end else begin
                st_d = ST_SCAN;
              end
            end
            default: begin
              strobe_d = 1'b1;
              ok_d     = 1'b0;
              last_d   = 1'b1;
            end
          endcase
        end
      end

      ST_SCAN: begin
        idx_d = is_end ? '0 : idx_q + 1'b1;
        unique case (func_q)
          FUNC_RESERVE: begin
            if (own) begin
              tail_taken_o = 1'b0;
              tail_owner_o = '0;
            end
            if (in_range && tail_taken_o) conflict_d = 1'b1;
            if (is_end) begin
              if (range_ok && !conflict_d) begin
                st_d = ST_CLAIM;
              end else begin
                st_d     = ST_IDLE;
                strobe_d = 1'b1;
                ok_d     = 1'b0;
                last_d   = 1'b1;
              end
            end
          end
          FUNC_RELEASE, FUNC_EXPIRE: begin
            if ((func_q == FUNC_RELEASE) ? own : (idx_q < cur_q)) begin
              tail_taken_o = 1'b0;
              tail_owner_o = '0;
            end
            if (is_end) begin
              st_d     = ST_IDLE;
              strobe_d = 1'b1;
              last_d   = 1'b1;
            end
          end
          FUNC_WINDOWS: begin
            if (idx_q != '0) begin
              if (!blocked && !inrun_q) begin
                inrun_d = 1'b1;
                start_d = idx_q;
              end
              if (blocked && inrun_q) begin
                inrun_d = 1'b0;
                new_v   = 1'b1;
                new_rs  = start_q;
                new_re  = idx_q - 1'b1;
              end
            end
            // run still open at the top slot closes there
            if (is_end && inrun_d) begin
              new_v  = 1'b1;
              new_rs = start_d;
              new_re = LastIdx;
            end
            if (is_end) st_d = ST_FLUSH;
          end
          FUNC_HELD: begin
            if ((idx_q != '0) && own) begin
              new_v  = 1'b1;
              new_rs = idx_q;
              new_re = idx_q;
            end
            if (is_end) st_d = ST_FLUSH;
          end
          default: st_d = ST_IDLE;
        endcase
        // one word held back so the final one can carry last
        if (new_v) begin
          if (pend_v_q) begin
            strobe_d = 1'b1;
            found_d  = 1'b1;
            rs_d     = pend_rs_q;
            re_d     = pend_re_q;
          end
          pend_v_d  = 1'b1;
          pend_rs_d = new_rs;
          pend_re_d = new_re;
        end
      end

      ST_CLAIM: begin
        idx_d = is_end ? '0 : idx_q + 1'b1;
        if (in_range) begin
          tail_taken_o = 1'b1;
          tail_owner_o = id_q;
        end
        if (is_end) begin
          st_d     = ST_IDLE;
          strobe_d = 1'b1;
          last_d   = 1'b1;
        end
      end

      ST_FLUSH: begin
        st_d     = ST_IDLE;
        strobe_d = 1'b1;
        last_d   = 1'b1;
        found_d  = pend_v_q;
        rs_d     = pend_v_q ? pend_rs_q : '0;
        re_d     = pend_v_q ? pend_re_q : '0;
      end

      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_IDLE;
      idx_q      <= '0;
      conflict_q <= 1'b0;
      inrun_q    <= 1'b0;
      pend_v_q   <= 1'b0;
      strobe_q   <= 1'b0;
    end else begin
      st_q       <= st_d;
      idx_q      <= idx_d;
      conflict_q <= conflict_d;
      inrun_q    <= inrun_d;
      pend_v_q   <= pend_v_d;
      strobe_q   <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    id_q      <= id_d;
    first_q   <= first_d;
    lastsl_q  <= lastsl_d;
    cur_q     <= cur_d;
    start_q   <= start_d;
    pend_rs_q <= pend_rs_d;
    pend_re_q <= pend_re_d;
    ok_q      <= ok_d;
    found_q   <= found_d;
    rs_q      <= rs_d;
    re_q      <= re_d;
    last_q    <= last_d;
  end

  assign busy_o         = (st_q != ST_IDLE);
  assign shift_o        = (st_q == ST_SCAN) || (st_q == ST_CLAIM);
  assign result_valid_o = strobe_q;
  assign ok_o           = ok_q;
  assign found_o        = found_q;
  assign range_start_o  = rs_q;
  assign range_end_o    = re_q;
  assign last_o         = last_q;

endmodule

// ----- design/slot_reservation_table_top.sv -----
// channel   direction  handshake                       word
// command   in         start_i & !busy_o               func, robot, first/last/current slot
// result    out        result_valid_o, one cycle only  ok, found, range_start/end, last
// config    in         cfg_valid_i & cfg_ready_o       resource_type
//
// the table is a ring of LAST_SLOT+1 cells that rotates once per pass through the head cell
// release, expire: one pass, result when the pass ends
// reserve: a release/check pass then, if the check passes, a claim pass
// queries: one pass plus a flush state; words stream out during the pass
// unknown commands and windows with resource_type 1 answer in the cycle after start
// reset empties the table and sets resource_type to 3; results cannot be stalled
module slot_reservation_table_top #(
  parameter int LAST_SLOT     = srt_pkg::LAST_SLOT_DEF,
  parameter int ROBOT_ID_BITS = srt_pkg::ROBOT_ID_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [srt_pkg::FUNC_W-1:0]  func_i,
  input  logic [srt_pkg::ROBOT_W-1:0] robot_i,
  input  logic [srt_pkg::SLOT_W-1:0]  first_slot_i,
  input  logic [srt_pkg::SLOT_W-1:0]  last_slot_i,
  input  logic [srt_pkg::SLOT_W-1:0]  current_slot_i,
  output logic                        result_valid_o,
  output logic                        ok_o,
  output logic                        found_o,
  output logic [srt_pkg::SLOT_W-1:0]  range_start_o,
  output logic [srt_pkg::SLOT_W-1:0]  range_end_o,
  output logic                        last_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [srt_pkg::RTYPE_W-1:0] cfg_data_i
);
  import srt_pkg::*;

  localparam int NumCells = LAST_SLOT + 1;

  logic [RTYPE_W-1:0] rtype_q;

  logic                     shift;
  logic                     tail_taken;
  logic [ROBOT_ID_BITS-1:0] tail_owner;
  logic [NumCells-1:0]      taken;
  logic [ROBOT_ID_BITS-1:0] owner [NumCells];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rtype_q <= RTYPE_RESET;
    end else if (cfg_valid_i) begin
      rtype_q <= cfg_data_i;
    end
  end

  // cell k takes from cell k+1, the last cell takes the updated head
  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    if (k == NumCells - 1) begin : g_tail
      srt_cell #(.OWNER_BITS(ROBOT_ID_BITS)) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .taken_i (tail_taken),
        .owner_i (tail_owner),
        .taken_o (taken[k]),
        .owner_o (owner[k])
      );
    end else begin : g_mid
      srt_cell #(.OWNER_BITS(ROBOT_ID_BITS)) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .taken_i (taken[k+1]),
        .owner_i (owner[k+1]),
        .taken_o (taken[k]),
        .owner_o (owner[k])
      );
    end
  end

  srt_ctrl #(
    .LAST_SLOT     (LAST_SLOT),
    .ROBOT_ID_BITS (ROBOT_ID_BITS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .func_i         (func_i),
    .robot_i        (robot_i),
    .first_slot_i   (first_slot_i),
    .last_slot_i    (last_slot_i),
    .current_slot_i (current_slot_i),
    .rtype_i        (rtype_q),
    .head_taken_i   (taken[0]),
    .head_owner_i   (owner[0]),
    .shift_o        (shift),
    .tail_taken_o   (tail_taken),
    .tail_owner_o   (tail_owner),
    .result_valid_o (result_valid_o),
    .ok_o           (ok_o),
    .found_o        (found_o),
    .range_start_o  (range_start_o),
    .range_end_o    (range_end_o),
    .last_o         (last_o)
  );

endmodule
